[sv/lifd_pkg.sv]
// Shared types, field widths and codes of the fractional delay line.
// No dependencies; used by the core and its output queue.

package lifd_pkg;

  localparam int unsigned SAMPLE_W      = 24;
  localparam int unsigned GAIN_W        = 16;
  localparam int unsigned DELAY_W       = 20;
  localparam int unsigned DLY_FRAC_W    = 8;
  localparam int unsigned TAP_W         = 12;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = DELAY_W;
  localparam int unsigned DEPTH_DEFAULT = 4096;
  localparam int unsigned OUT_DEPTH     = 4;

  localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd16384;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_ADD   = 2'd3
  } kind_e;

  // clip a wide signed value to the sample range
  function automatic sample_t sat41(input logic signed [40:0] x);
    sample_t r;
    if (x > 41'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -41'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/lifd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; read during write to the same address returns the old data.

module lifd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/lifd_out_fifo.sv]
// Small result queue between the datapath and the output channel.
// Depends on lifd_pkg for the sample type; the caller guarantees it never overflows.

module lifd_out_fifo #(
  parameter int unsigned DEPTH = lifd_pkg::OUT_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lifd_pkg::sample_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lifd_pkg::sample_t data_o
);

  import lifd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  sample_t        mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  ap_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < CW'(DEPTH)) || pop)
    else $error("result queue overflow");

  ap_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("result queue count lost a push");

  ap_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && cnt_q == '0) |=> valid_o)
    else $error("pushed beat not presented");

endmodule

[sv/linear_interp_fractional_delay_core.sv]
// Fractional delay line with linear interpolation, top level.
// Depends on lifd_pkg, lifd_ram and lifd_out_fifo.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one beat per operation:
//   kind_i selects tick, tap read, tap write or tap add; sample_in_i is the
//   sample or tap value and tap_offset_i the tap age. Each beat yields exactly
//   one beat on the output channel (out_valid_o/out_ready_i), in order.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle.
//   A tick reads two entries of the delay RAM, which has a single read port,
//   so in_ready_o drops while a beat waits in stage 1; a new beat is taken
//   while the last is still in stage 2.
//   Every read-modify-write finishes before the next beat reads the RAM.
//   Reset: the delay RAM is swept to zero, one entry per cycle, over all DEPTH
//   entries (4096 by default); in_ready_o stays low meanwhile, configuration
//   writes are still taken.
//   Stall: up to 4 results wait in an output queue; in_ready_o drops while
//   4 beats are accepted and not yet taken, so nothing is lost.

module linear_interp_fractional_delay_core #(
  parameter int unsigned DEPTH = lifd_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lifd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lifd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [lifd_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [lifd_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [lifd_pkg::TAP_W-1:0]           tap_offset_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [lifd_pkg::SAMPLE_W-1:0] sample_out_o
);

  import lifd_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SH    = TAP_W + AW;
  localparam int unsigned QP_W  = 2 * TAP_W + 2;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

  // configuration
  logic [DELAY_W-1:0] dly_q;
  logic [GAIN_W-1:0]  gain_q;

  // clearing sweep
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  // write pointer and outstanding beats
  logic [AW-1:0]    w_q, w_d;
  logic [CNT_W-1:0] cnt_q;

  logic accept, pop;

  // stage 1: registered beat, gain product, tap quotient
  logic               s1_valid_q;
  kind_e              s1_kind_q;
  sample_t            s1_sample_q;
  logic [TAP_W-1:0]   s1_tap_q;
  logic [TAP_W-1:0]   s1_quo_q, s1_quo_d;
  logic signed [40:0] s1_prod_q, s1_prod_d;

  // stage 1 address and write value logic
  logic [TAP_W-1:0]      n_raw;
  logic                  n_clamp;
  logic [AW-1:0]         n_c;
  logic [DLY_FRAC_W-1:0] f_c;
  logic [AW:0]           a_diff, t_diff;
  logic [AW-1:0]         a_addr, b_addr, t_addr, tap_rem;
  logic [TAP_W-1:0]      quo_mul, rem12;
  logic signed [40:0]    rnd;
  sample_t               wval_d;

  // stage 2: RAM accesses
  logic                  s2_valid_q, s2_second_q;
  kind_e                 s2_kind_q;
  sample_t               s2_sample_q, s2_wval_q;
  logic [AW-1:0]         s2_waddr_q, s2_addr0_q, s2_addr1_q;
  logic [DLY_FRAC_W-1:0] s2_frac_q;

  // stage 3: interpolation
  logic                  s3_valid_q;
  kind_e                 s3_kind_q;
  sample_t               s3_val_q, s3_val_d;
  logic [DLY_FRAC_W-1:0] s3_frac_q;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  sample_t       ram_wdata, ram_rdata;

  sample_t            tap_val, fwd_a, res;
  logic signed [24:0] ip_dif;
  logic signed [33:0] ip_mul, ip_acc, ip_sh;
  logic               fifo_valid;
  sample_t            fifo_data;

  assign in_ready_o = !s1_valid_q && !clr_q && (cnt_q < CNT_W'(OUT_DEPTH));
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = fifo_valid && out_ready_i;

  assign s1_prod_d = sample_in_i * $signed({1'b0, gain_q});
  assign s1_quo_d  = TAP_W'((QP_W'(tap_offset_i) * QP_W'(RECIP)) >> SH);

  // stage 1: addresses and gained sample
  always_comb begin
    n_raw   = dly_q[DELAY_W-1:DLY_FRAC_W];
    n_clamp = 32'(n_raw) > (DEPTH - 1);
    n_c     = n_clamp ? LAST : AW'(n_raw);
    f_c     = n_clamp ? '0 : dly_q[DLY_FRAC_W-1:0];

    a_diff  = {1'b0, w_q} + DEPTH_X - {1'b0, n_c};
    a_addr  = (a_diff >= DEPTH_X) ? AW'(a_diff - DEPTH_X) : AW'(a_diff);
    b_addr  = (a_addr == '0) ? LAST : a_addr - 1'b1;

    quo_mul = TAP_W'(32'(s1_quo_q) * DEPTH);
    rem12   = s1_tap_q - quo_mul;
    tap_rem = AW'(rem12);
    t_diff  = {1'b0, w_q} + DEPTH_X - ((AW+1)'(tap_rem) + (AW+1)'(1));
    t_addr  = (t_diff >= DEPTH_X) ? AW'(t_diff - DEPTH_X) : AW'(t_diff);

    rnd     = (s1_prod_q + 41'sd8192) >>> 14;
    wval_d  = sat41(rnd);

    w_d = w_q;
    if (s1_valid_q && s1_kind_q == KIND_TICK) begin
      w_d = (w_q == LAST) ? '0 : w_q + 1'b1;
    end
  end

  // stage 2 read-data step: tap value, forwarding of the tick's own write
  always_comb begin
    tap_val = (s2_kind_q == KIND_WRITE) ? s2_sample_q
                                        : sat41(41'(ram_rdata) + 41'(s2_sample_q));
    fwd_a   = (s2_addr0_q == s2_waddr_q) ? s2_wval_q : ram_rdata;
    unique case (s2_kind_q)
      KIND_TICK:  s3_val_d = fwd_a;
      KIND_READ:  s3_val_d = ram_rdata;
      KIND_WRITE: s3_val_d = tap_val;
      KIND_ADD:   s3_val_d = tap_val;
      default:    s3_val_d = ram_rdata;
    endcase
  end

  // stage 3: (256-f)*a + f*b, rounded and clipped, for a tick; other kinds pass through
  always_comb begin
    ip_dif = 25'(ram_rdata) - 25'(s3_val_q);
    ip_mul = ip_dif * $signed({1'b0, s3_frac_q});
    ip_acc = (34'(s3_val_q) <<< DLY_FRAC_W) + ip_mul + 34'sd128;
    ip_sh  = ip_acc >>> DLY_FRAC_W;
    res    = (s3_kind_q == KIND_TICK) ? sat41(41'(ip_sh)) : s3_val_q;
  end

  // RAM port arbitration
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s2_addr0_q;
    ram_wdata = tap_val;
    ram_raddr = s2_second_q ? s2_addr1_q : s2_addr0_q;
    priority if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (s2_valid_q && !s2_second_q && s2_kind_q == KIND_TICK) begin
      ram_we    = 1'b1;
      ram_waddr = s2_waddr_q;
      ram_wdata = s2_wval_q;
    end else if (s2_valid_q && s2_second_q &&
                 (s2_kind_q == KIND_WRITE || s2_kind_q == KIND_ADD)) begin
      ram_we    = 1'b1;
    end else begin
      ram_we    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q       <= '0;
      gain_q      <= GAIN_RESET;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      w_q         <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_second_q <= 1'b0;
      s3_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DELAY: dly_q  <= cfg_wdata_i;
          CFG_GAIN:  gain_q <= cfg_wdata_i[GAIN_W-1:0];
          default:   dly_q  <= dly_q;
        endcase
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == LAST) begin
          clr_q <= 1'b0;
        end
      end
      w_q   <= w_d;
      cnt_q <= cnt_q + CNT_W'(accept) - CNT_W'(pop);
      s1_valid_q <= accept;
      if (s1_valid_q) begin
        s2_valid_q  <= 1'b1;
        s2_second_q <= 1'b0;
      end else if (s2_valid_q && !s2_second_q) begin
        s2_second_q <= 1'b1;
      end else begin
        s2_valid_q  <= 1'b0;
        s2_second_q <= 1'b0;
      end
      s3_valid_q <= s2_valid_q && s2_second_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q   <= kind_e'(kind_i);
      s1_sample_q <= sample_in_i;
      s1_tap_q    <= tap_offset_i;
      s1_quo_q    <= s1_quo_d;
      s1_prod_q   <= s1_prod_d;
    end
    if (s1_valid_q) begin
      s2_kind_q   <= s1_kind_q;
      s2_sample_q <= s1_sample_q;
      s2_wval_q   <= wval_d;
      s2_waddr_q  <= w_q;
      s2_addr0_q  <= (s1_kind_q == KIND_TICK) ? a_addr : t_addr;
      s2_addr1_q  <= b_addr;
      s2_frac_q   <= f_c;
    end
    if (s2_valid_q && s2_second_q) begin
      s3_kind_q <= s2_kind_q;
      s3_val_q  <= s3_val_d;
      s3_frac_q <= s2_frac_q;
    end
  end

  lifd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lifd_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s3_valid_q),
    .data_i  (res),
    .valid_o (fifo_valid),
    .ready_i (out_ready_i),
    .data_o  (fifo_data)
  );

  assign out_valid_o  = fifo_valid;
  assign sample_out_o = fifo_data;

  ap_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !(in_valid_i && in_ready_o))
    else $error("beats accepted closer than two cycles");

  ap_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_valid_q && !s2_valid_q && !s3_valid_q)
    else $error("beat in flight during clearing sweep");

  ap_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OUT_DEPTH))
    else $error("more beats outstanding than queue slots");

  ap_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_kind_q == KIND_TICK) |=> w_q != $past(w_q))
    else $error("tick did not advance write pointer");

  ap_tap_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_kind_q != KIND_TICK) |=> $stable(w_q))
    else $error("tap beat moved write pointer");

endmodule

[tb/tb.sv]
// Testbench for linear_interp_fractional_delay_core: directed and random beats,
// each checked against a built-in delay line predictor.
// Depends on lifd_pkg and the core RTL.

module tb;
  import lifd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_DEPTH = DEPTH_DEFAULT;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam sample_t S_MAX = 24'sh7FFFFF;
  localparam sample_t S_MIN = 24'sh800000;

  typedef logic [TAP_W-1:0] tap_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_DELAY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  logic [KIND_W-1:0]     kind = KIND_TICK;
  sample_t               sample_in = '0;
  tap_t                  tap_offset = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  sample_t               sample_out_o;

  sample_t               dline [LINE_DEPTH];
  tap_t                  wr_ptr;
  logic [DELAY_W-1:0]    dly_cfg;
  logic [GAIN_W-1:0]     gain_cfg;
  sample_t               expected_out [$];
  bit                    failed = 1'b0;
  bit                    no_idle = 1'b0;
  int unsigned           stall_cycles = 0;

  linear_interp_fractional_delay_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind),
    .sample_in_i (sample_in),
    .tap_offset_i(tap_offset),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .sample_out_o(sample_out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic sample_t clip24(longint x);
    if (x > longint'(S_MAX)) return S_MAX;
    if (x < longint'(S_MIN)) return S_MIN;
    return sample_t'(x);
  endfunction

  function automatic sample_t delay_line_step(kind_e k, sample_t s, tap_t t);
    int unsigned n;
    longint wf, wa, a, b;
    tap_t ad;
    sample_t r;
    if (k == KIND_TICK) begin
      n = dly_cfg >> DLY_FRAC_W;
      wf = dly_cfg[DLY_FRAC_W-1:0];
      if (n > LINE_DEPTH - 1) begin
        n = LINE_DEPTH - 1;
        wf = 0;
      end
      wa = 256 - wf;
      dline[wr_ptr] = clip24((longint'(s) * longint'(gain_cfg) + 8192) >>> 14);
      ad = wr_ptr - tap_t'(n);
      a = dline[ad];
      ad = ad - tap_t'(1);
      b = dline[ad];
      r = clip24((wa * a + wf * b + 128) >>> 8);
      wr_ptr = wr_ptr + tap_t'(1);
    end else begin
      ad = wr_ptr - t - tap_t'(1);
      case (k)
        KIND_READ: begin
          r = dline[ad];
        end
        KIND_WRITE: begin
          r = s;
          dline[ad] = r;
        end
        default: begin
          r = clip24(longint'(dline[ad]) + longint'(s));
          dline[ad] = r;
        end
      endcase
    end
    return r;
  endfunction

  // receiver side back-pressure
  always @(posedge clk_i) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 33);
    end
  end

  // result check and watchdog, sampled mid-cycle when everything is stable
  always @(negedge clk_i) begin
    if ((in_valid && in_ready_o) || (rst_ni && out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_out.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual sample_out %0d",
                 $time, sample_out_o);
        failed = 1'b1;
      end else if (sample_out_o !== expected_out[0]) begin
        $display("%0t sample_out mismatch: expected %0d, actual %0d",
                 $time, expected_out[0], sample_out_o);
        failed = 1'b1;
        void'(expected_out.pop_front());
      end else begin
        void'(expected_out.pop_front());
      end
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles, %0d results pending",
               $time, STALL_LIMIT, expected_out.size());
      $display("** linear_interp_fractional_delay_core: FAILED **");
      $finish;
    end
  end

  task automatic send_beat(input kind_e k, input sample_t s, input tap_t t);
    if (!no_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    sample_in  <= s;
    tap_offset <= t;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    expected_out.push_back(delay_line_step(k, s, t));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [DELAY_W-1:0] d, input logic [GAIN_W-1:0] g);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DELAY;
    cfg_wdata <= d;
    @(posedge clk_i);
    cfg_idx   <= CFG_GAIN;
    cfg_wdata <= CFG_DATA_W'(g);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    dly_cfg  = d;
    gain_cfg = g;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return S_MAX;
      1: return S_MIN;
      2: return sample_t'($urandom_range(64)) - sample_t'(32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // delay zero, unity gain straight out of reset
  task automatic test_reset_defaults();
    send_beat(KIND_TICK, S_MAX, '0);
    send_beat(KIND_TICK, S_MIN, '0);
    send_beat(KIND_TICK, -24'sd1, '0);
    send_beat(KIND_TICK, 24'sd1, '0);
    send_beat(KIND_TICK, '0, '0);
  endtask

  task automatic test_gain_limits();
    drain();
    set_config({12'd1, 8'd0}, 16'hFFFF);
    send_beat(KIND_TICK, S_MAX, '0);
    send_beat(KIND_TICK, S_MIN, '0);
    send_beat(KIND_TICK, 24'sh200000, '0);
    drain();
    set_config(20'h00080, 16'd0);
    send_beat(KIND_TICK, S_MAX, '0);
    send_beat(KIND_TICK, 24'sd1, '0);
  endtask

  // longest delay with the largest fraction, then a fractional short delay
  task automatic test_delay_limits();
    drain();
    set_config(20'hFFFFF, GAIN_RESET);
    repeat (3) send_beat(KIND_TICK, pick_sample(), '0);
    drain();
    set_config(20'h002FF, 16'd8192);
    send_beat(KIND_TICK, S_MAX, '0);
    send_beat(KIND_TICK, S_MIN, '0);
    send_beat(KIND_TICK, 24'sd3, '0);
  endtask

  // tap access at both ends of the line and add saturation both ways
  task automatic test_tap_ops();
    drain();
    set_config(20'h00300, GAIN_RESET);
    send_beat(KIND_WRITE, S_MAX, '0);
    send_beat(KIND_ADD, S_MAX, '0);
    send_beat(KIND_WRITE, S_MIN, '1);
    send_beat(KIND_ADD, S_MIN, '1);
    send_beat(KIND_READ, '0, '1);
    send_beat(KIND_READ, '0, '0);
    send_beat(KIND_ADD, -24'sd5, 12'd7);
    send_beat(KIND_TICK, 24'sd100, '0);
  endtask

  task automatic test_random_traffic();
    logic [DELAY_W-1:0] d;
    logic [GAIN_W-1:0] g;
    int unsigned n;
    kind_e k;
    tap_t t;
    for (int phase = 0; phase < 10; phase++) begin
      drain();
      case ($urandom_range(3))
        0: d = DELAY_W'($urandom_range(20'h008FF));
        1: d = DELAY_W'($urandom);
        2: d = {12'd4095, 8'($urandom)};
        default: d = {12'($urandom_range(16)), 8'd0};
      endcase
      case ($urandom_range(3))
        0: g = GAIN_W'($urandom);
        1: g = GAIN_RESET;
        2: g = 16'hFFFF;
        default: g = GAIN_W'($urandom_range(32768));
      endcase
      set_config(d, g);
      no_idle = (phase == 4 || phase == 5);
      n = d >> DLY_FRAC_W;
      repeat (100) begin
        case ($urandom_range(7))
          0, 1, 2, 3: k = KIND_TICK;
          4: k = KIND_READ;
          5: k = KIND_WRITE;
          6: k = KIND_ADD;
          default: k = kind_e'($urandom_range(3));
        endcase
        if ($urandom_range(3) == 0) begin
          t = tap_t'($urandom);
        end else begin
          t = tap_t'($urandom_range((n > 4090) ? 4095 : n + 2));
        end
        send_beat(k, pick_sample(), t);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (dline[i]) dline[i] = '0;
    wr_ptr   = '0;
    dly_cfg  = '0;
    gain_cfg = GAIN_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_gain_limits();
    test_delay_limits();
    test_tap_ops();
    test_random_traffic();
    drain();
    if (!failed && expected_out.size() == 0) begin
      $display("** linear_interp_fractional_delay_core: PASSED **");
    end else begin
      $display("** linear_interp_fractional_delay_core: FAILED **");
    end
    $finish;
  end

endmodule
